@@ rtl/i2cts_pkg.sv @@
// i2cts_pkg: shared types and constants of the i2c target line sampler
// holds the bus phase codes, the register indexes and the state/result structs
// no dependencies
`default_nettype none

package i2cts_pkg;

   // phase flag bits: busy, selected, read, master acked; low nibble is the step
   localparam logic [7:0] PH_IDLE     = 8'h00;
   localparam logic [7:0] PH_ADDR     = 8'h80;
   localparam logic [7:0] PH_IGNORE   = 8'h82;
   localparam logic [7:0] PH_WR_DATA  = 8'hC0;
   localparam logic [7:0] PH_WR_ACK   = 8'hC1;
   localparam logic [7:0] PH_WR_AACK  = 8'hC3;
   localparam logic [7:0] PH_RD_FIRST = 8'hE0;
   localparam logic [7:0] PH_RD_SLOT  = 8'hE1;
   localparam logic [7:0] PH_RD_NACK  = 8'hE2;
   localparam logic [7:0] PH_RD_AACK  = 8'hE3;
   localparam logic [7:0] PH_RD_NEXT  = 8'hF0;
   localparam logic [7:0] PH_RD_SLOTA = 8'hF1;

   localparam int FL_USE_BIT    = 7;
   localparam int FL_DEVICE_BIT = 6;
   localparam int FL_WR_BIT     = 5;
   localparam int FL_ACK_BIT    = 4;

   localparam logic [3:0] BYTE_BITS = 4'd8;

   // configuration register indexes
   localparam logic CSR_OWN_ADDRESS   = 1'b0;
   localparam logic CSR_TIMEOUT_LIMIT = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [7:0]  phase;
      logic [7:0]  shift;
      logic [3:0]  bit_count;
      logic [15:0] wait_count;
      logic        last_scl;
      logic        last_sda;
      logic        drive_low;
   } state_type;

   typedef struct packed {
      logic       sda_pull_low;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       tx_pop;
      logic       addressed;
      logic       read_transfer;
      logic       bus_busy;
      logic       timeout_flag;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:      PH_IDLE,
      shift:      8'h00,
      bit_count:  4'd0,
      wait_count: 16'd0,
      last_scl:   1'b1,
      last_sda:   1'b1,
      drive_low:  1'b0
   };

endpackage : i2cts_pkg

`default_nettype wire

@@ rtl/i2cts_core.sv @@
// i2cts_core: next-state and result logic for one line sample
// purely combinational; uses i2cts_pkg for phase codes and structs
`default_nettype none

module i2cts_core
   import i2cts_pkg::*;
(
   input  wire state_type   cur,
   input  wire logic        scl,
   input  wire logic        sda,
   input  wire logic [7:0]  tx_byte,
   input  wire logic [6:0]  own_address,
   input  wire logic [15:0] timeout_limit,
   output state_type        nxt,
   output result_type       res
);

   // enter a phase with shifter, counters and sda drive cleared
   function automatic state_type go_phase(state_type s, logic [7:0] ph);
      state_type r;
      r            = s;
      r.phase      = ph;
      r.shift      = 8'h00;
      r.bit_count  = 4'd0;
      r.wait_count = 16'd0;
      r.drive_low  = 1'b0;
      return r;
   endfunction

   // put the msb of a new transmit byte on the line, keep the rest
   function automatic state_type load_tx(state_type s, logic [7:0] b, logic [7:0] ph);
      state_type r;
      r           = s;
      r.drive_low = ~b[7];
      r.shift     = {b[6:0], 1'b0};
      r.bit_count = 4'd1;
      r.phase     = ph;
      return r;
   endfunction

   logic       rise;
   logic       fall;
   logic       high;
   logic [3:0] step;
   logic       rd;
   logic       rxv;
   logic [7:0] rxb;
   logic       pop;
   logic       tmo;
   state_type  s;

   assign rise = ~cur.last_scl & scl;
   assign fall = cur.last_scl & ~scl;
   assign high = cur.last_scl & scl;
   assign step = cur.phase[3:0];
   assign rd   = cur.phase[FL_WR_BIT];

   always_comb begin
      s   = cur;
      rxv = 1'b0;
      rxb = 8'h00;
      pop = 1'b0;
      tmo = 1'b0;
      if (high && cur.last_sda && !sda) begin
         // start or repeated start
         s = go_phase(cur, PH_ADDR);
      end else if (high && !cur.last_sda && sda) begin
         // stop
         s = go_phase(cur, PH_IDLE);
      end else if (cur.phase == PH_IDLE) begin
         s = cur;
      end else if (rise) begin
         s.wait_count = 16'd0;
         if (step == 4'd0 && !rd) begin
            if (cur.bit_count < BYTE_BITS) begin
               s.shift     = {cur.shift[6:0], sda};
               s.bit_count = cur.bit_count + 4'd1;
            end
         end else if (step == 4'd1 && rd) begin
            s.phase[FL_ACK_BIT] = ~sda;
         end
      end else if (fall) begin
         s.wait_count = 16'd0;
         case (cur.phase) inside
            PH_ADDR: begin
               if (cur.bit_count >= BYTE_BITS) begin
                  if (cur.shift[7:1] == own_address) begin
                     s.phase     = cur.shift[0] ? PH_RD_AACK : PH_WR_AACK;
                     s.drive_low = 1'b1;
                     s.bit_count = 4'd0;
                  end else begin
                     s = go_phase(cur, PH_IGNORE);
                  end
               end
            end
            PH_WR_DATA: begin
               if (cur.bit_count >= BYTE_BITS) begin
                  s.phase     = PH_WR_ACK;
                  s.drive_low = 1'b1;
               end
            end
            PH_WR_ACK: begin
               rxv = 1'b1;
               rxb = cur.shift;
               s   = go_phase(cur, PH_WR_DATA);
            end
            PH_WR_AACK: begin
               s = go_phase(cur, PH_WR_DATA);
            end
            PH_RD_AACK: begin
               pop = 1'b1;
               s   = load_tx(s, tx_byte, PH_RD_FIRST);
            end
            PH_RD_FIRST, PH_RD_NEXT: begin
               if (cur.bit_count < BYTE_BITS) begin
                  s.drive_low = ~cur.shift[7];
                  s.shift     = {cur.shift[6:0], 1'b0};
                  s.bit_count = cur.bit_count + 4'd1;
               end else begin
                  // byte done, release sda for the master ack
                  s.drive_low = 1'b0;
                  s.bit_count = 4'd0;
                  s.phase     = {cur.phase[7:4], 4'h1};
               end
            end
            PH_RD_SLOT, PH_RD_SLOTA: begin
               if (cur.phase[FL_ACK_BIT]) begin
                  pop = 1'b1;
                  s   = load_tx(s, tx_byte, PH_RD_NEXT);
               end else begin
                  s = go_phase(cur, PH_RD_NACK);
               end
            end
            default: begin
               s = s;
            end
         endcase
      end else begin
         // no scl edge: count toward timeout
         if (cur.wait_count >= timeout_limit) begin
            tmo = 1'b1;
            s   = go_phase(cur, PH_IDLE);
         end else begin
            s.wait_count = cur.wait_count + 16'd1;
         end
      end
      s.last_scl = scl;
      s.last_sda = sda;
   end

   assign nxt = s;

   assign res.sda_pull_low  = s.drive_low;
   assign res.rx_valid      = rxv;
   assign res.rx_byte       = rxb;
   assign res.tx_pop        = pop;
   assign res.addressed     = s.phase[FL_DEVICE_BIT];
   assign res.read_transfer = s.phase[FL_DEVICE_BIT] & s.phase[FL_WR_BIT];
   assign res.bus_busy      = s.phase[FL_USE_BIT];
   assign res.timeout_flag  = tmo;

endmodule : i2cts_core

`default_nettype wire

@@ rtl/i2c_target_line_sampler_unit.sv @@
// i2c_target_line_sampler_unit: oversampled i2c target with 7-bit address
// top level; uses i2cts_pkg and i2cts_core
// pipeline: an accepted sample waits in the input register, and its result moves
//   into the result register whenever that register is empty or being drained
// throughput: one sample per cycle; the input register keeps filling while the
//   result waits, and req_stall rises only when both registers hold an item
// reset (synchronous): pipeline empty, bus idle, own_address 0,
//   timeout_limit 1000, last line levels high
`default_nettype none

module i2c_target_line_sampler_unit
   import i2cts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // sample channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_scl_level,
   input  wire logic        req_sda_level,
   input  wire logic [7:0]  req_tx_byte,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_sda_pull_low,
   output logic             rsp_rx_valid,
   output logic [7:0]       rsp_rx_byte,
   output logic             rsp_tx_pop,
   output logic             rsp_addressed,
   output logic             rsp_read_transfer,
   output logic             rsp_bus_busy,
   output logic             rsp_timeout_flag,
   // configuration writes
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   // configuration registers
   logic [6:0]  own_address_ff;
   logic [15:0] timeout_limit_ff;

   // input register stage
   logic        in_valid_ff;
   logic        in_scl_ff;
   logic        in_sda_ff;
   logic [7:0]  in_tx_ff;

   // protocol state and result register
   state_type   state_ff;
   state_type   state_in;
   result_type  res_in;
   result_type  rsp_ff;
   logic        rsp_valid_ff;

   logic        advance;
   logic        in_load;

   // the result register can take a new item when empty or being drained
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   // the input register frees up whenever its item moves on
   assign req_stall = in_valid_ff & ~advance;
   assign in_load   = req_valid & ~req_stall;

   i2cts_core u_core (
      .cur           (state_ff),
      .scl           (in_scl_ff),
      .sda           (in_sda_ff),
      .tx_byte       (in_tx_ff),
      .own_address   (own_address_ff),
      .timeout_limit (timeout_limit_ff),
      .nxt           (state_in),
      .res           (res_in)
   );

   // configuration write decoder
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff   <= 7'd0;
         timeout_limit_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:   own_address_ff   <= csr_wdata[6:0];
            CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata;
            default:           own_address_ff   <= own_address_ff;
         endcase
      end
   end

   // input register: filled by a new item, kept while its item waits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_load | (in_valid_ff & ~advance);
      end
      if (in_load) begin
         in_scl_ff <= req_scl_level;
         in_sda_ff <= req_sda_level;
         in_tx_ff  <= req_tx_byte;
      end
   end

   // protocol state advances only on the item that moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            state_ff <= state_in;
         end
      end
      if (advance && in_valid_ff) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sda_pull_low  = rsp_ff.sda_pull_low;
   assign rsp_rx_valid      = rsp_ff.rx_valid;
   assign rsp_rx_byte       = rsp_ff.rx_byte;
   assign rsp_tx_pop        = rsp_ff.tx_pop;
   assign rsp_addressed     = rsp_ff.addressed;
   assign rsp_read_transfer = rsp_ff.read_transfer;
   assign rsp_bus_busy      = rsp_ff.bus_busy;
   assign rsp_timeout_flag  = rsp_ff.timeout_flag;

   // a received byte and a transmit pop never share one item
   a_rx_pop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.rx_valid && rsp_ff.tx_pop))
      else $error("rx strobe and tx pop in the same item");

   // selection implies a busy bus, a read implies selection
   a_sel_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.read_transfer |-> rsp_ff.addressed && rsp_ff.bus_busy)
      else $error("read transfer flagged outside a selected transfer");

   // a timeout always leaves the bus idle
   a_tmo_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.timeout_flag |-> !rsp_ff.bus_busy && !rsp_ff.sda_pull_low)
      else $error("timeout without return to idle");

   // received byte reads zero when no byte is strobed
   a_rx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.rx_valid |-> rsp_ff.rx_byte == 8'h00)
      else $error("rx byte nonzero without strobe");

   // sda is never pulled low while the target is not selected
   a_drive_sel: assert property (@(posedge clock) disable iff (reset)
      state_ff.drive_low |-> state_ff.phase[FL_DEVICE_BIT])
      else $error("sda driven while not selected");

endmodule : i2c_target_line_sampler_unit

`default_nettype wire

@@ verif/i2cts_checker.sv @@
// i2cts_checker: response predictor and scoreboard for the i2c target line sampler
// tracks register writes, predicts one response per accepted sample, compares in order
// depends on i2cts_pkg
`default_nettype none

module i2cts_checker
   import i2cts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_scl_level,
   input  wire logic        req_sda_level,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_sda_pull_low,
   input  wire logic        rsp_rx_valid,
   input  wire logic [7:0]  rsp_rx_byte,
   input  wire logic        rsp_tx_pop,
   input  wire logic        rsp_addressed,
   input  wire logic        rsp_read_transfer,
   input  wire logic        rsp_bus_busy,
   input  wire logic        rsp_timeout_flag,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   output int unsigned      error_count,
   output int unsigned      pending_count
);

   logic [6:0]  own_addr;
   logic [15:0] tmo_limit;
   logic [7:0]  bus_phase;
   logic [7:0]  shreg;
   logic [3:0]  bits_seen;
   logic [15:0] wait_cnt;
   logic        prev_scl;
   logic        prev_sda;
   logic        pull_low;

   result_type  pending_responses[$];

   task automatic enter_phase(input logic [7:0] ph);
      bus_phase = ph;
      shreg     = 8'h00;
      bits_seen = 4'd0;
      wait_cnt  = 16'd0;
      pull_low  = 1'b0;
   endtask

   task automatic load_tx_byte(input logic [7:0] b, input logic [7:0] ph);
      pull_low  = ~b[7];
      shreg     = {b[6:0], 1'b0};
      bits_seen = 4'd1;
      bus_phase = ph;
   endtask

   task automatic predict_bus_response(input logic scl, input logic sda,
                                       input logic [7:0] tx, output result_type r);
      logic       rise;
      logic       fall;
      logic       high;
      logic       rd;
      logic [3:0] stp;
      r    = '0;
      rise = !prev_scl && scl;
      fall = prev_scl && !scl;
      high = prev_scl && scl;
      stp  = bus_phase[3:0];
      rd   = bus_phase[FL_WR_BIT];

      if (high && prev_sda && !sda) begin
         enter_phase(PH_ADDR);
      end else if (high && !prev_sda && sda) begin
         enter_phase(PH_IDLE);
      end else if (bus_phase == PH_IDLE) begin
         // only a start gets out of idle
      end else if (rise) begin
         wait_cnt = 16'd0;
         if (stp == 4'd0 && !rd) begin
            if (bits_seen < BYTE_BITS) begin
               shreg     = {shreg[6:0], sda};
               bits_seen = bits_seen + 4'd1;
            end
         end else if (stp == 4'd1 && rd) begin
            bus_phase[FL_ACK_BIT] = !sda;
         end
      end else if (fall) begin
         wait_cnt = 16'd0;
         if (bus_phase == PH_ADDR) begin
            if (bits_seen >= BYTE_BITS) begin
               if (shreg[7:1] == own_addr) begin
                  bus_phase = shreg[0] ? PH_RD_AACK : PH_WR_AACK;
                  pull_low  = 1'b1;
                  bits_seen = 4'd0;
               end else begin
                  enter_phase(PH_IGNORE);
               end
            end
         end else if (bus_phase == PH_WR_DATA) begin
            if (bits_seen >= BYTE_BITS) begin
               bus_phase = PH_WR_ACK;
               pull_low  = 1'b1;
            end
         end else if (bus_phase == PH_WR_ACK) begin
            r.rx_valid = 1'b1;
            r.rx_byte  = shreg;
            enter_phase(PH_WR_DATA);
         end else if (bus_phase == PH_WR_AACK) begin
            enter_phase(PH_WR_DATA);
         end else if (bus_phase == PH_RD_AACK) begin
            r.tx_pop = 1'b1;
            load_tx_byte(tx, PH_RD_FIRST);
         end else if (rd && stp == 4'd0) begin
            if (bits_seen < BYTE_BITS) begin
               pull_low  = ~shreg[7];
               shreg     = {shreg[6:0], 1'b0};
               bits_seen = bits_seen + 4'd1;
            end else begin
               pull_low  = 1'b0;
               bits_seen = 4'd0;
               bus_phase = {bus_phase[7:4], 4'd1};
            end
         end else if (rd && stp == 4'd1) begin
            if (bus_phase[FL_ACK_BIT]) begin
               r.tx_pop = 1'b1;
               load_tx_byte(tx, PH_RD_NEXT);
            end else begin
               enter_phase(PH_RD_NACK);
            end
         end
      end else begin
         // no edge, start or stop: count toward the timeout
         if (wait_cnt >= tmo_limit) begin
            r.timeout_flag = 1'b1;
            enter_phase(PH_IDLE);
         end else begin
            wait_cnt = wait_cnt + 16'd1;
         end
      end

      prev_scl = scl;
      prev_sda = sda;

      r.sda_pull_low  = pull_low;
      r.addressed     = bus_phase[FL_DEVICE_BIT];
      r.read_transfer = bus_phase[FL_DEVICE_BIT] & bus_phase[FL_WR_BIT];
      r.bus_busy      = bus_phase[FL_USE_BIT];
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type seen;
      if (reset) begin
         own_addr  = 7'd0;
         tmo_limit = TIMEOUT_RESET;
         enter_phase(PH_IDLE);
         prev_scl  = 1'b1;
         prev_sda  = 1'b1;
         pending_responses.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_OWN_ADDRESS) own_addr = csr_wdata[6:0];
            else tmo_limit = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{sda_pull_low: rsp_sda_pull_low, rx_valid: rsp_rx_valid,
                     rx_byte: rsp_rx_byte, tx_pop: rsp_tx_pop, addressed: rsp_addressed,
                     read_transfer: rsp_read_transfer, bus_busy: rsp_bus_busy,
                     timeout_flag: rsp_timeout_flag};
            if (pending_responses.size() == 0) begin
               $error("response item with nothing expected");
               error_count++;
            end else begin
               want = pending_responses.pop_front();
               check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(seen.sda_pull_low));
               check_field("rx_valid", 8'(want.rx_valid), 8'(seen.rx_valid));
               check_field("rx_byte", want.rx_byte, seen.rx_byte);
               check_field("tx_pop", 8'(want.tx_pop), 8'(seen.tx_pop));
               check_field("addressed", 8'(want.addressed), 8'(seen.addressed));
               check_field("read_transfer", 8'(want.read_transfer),
                           8'(seen.read_transfer));
               check_field("bus_busy", 8'(want.bus_busy), 8'(seen.bus_busy));
               check_field("timeout_flag", 8'(want.timeout_flag), 8'(seen.timeout_flag));
            end
         end
         if (req_valid && !req_stall) begin
            predict_bus_response(req_scl_level, req_sda_level, req_tx_byte, want);
            pending_responses.push_back(want);
         end
      end
      pending_count = pending_responses.size();
   end

endmodule : i2cts_checker

`default_nettype wire

@@ verif/tb_i2c_target_line_sampler_unit.sv @@
// tb_i2c_target_line_sampler_unit: stimulus and verdict for the i2c target line sampler
// drives oversampled bus waveforms and register writes; checking lives in i2cts_checker
// depends on i2cts_pkg, i2cts_checker and i2c_target_line_sampler_unit
`default_nettype none

module tb_i2c_target_line_sampler_unit;
   import i2cts_pkg::*;

   // watchdog, far above the slowest legal run
   localparam int CYCLE_LIMIT = 200000;
   // random samples per phase of the run; the last transfer of a phase runs over
   localparam int PHASE_ITEMS = 160;
   // directed sequence, two bits per sample: {scl, sda}
   //   start, stop while addressing, start, scl and sda changing together twice,
   //   stop, stop while idle, start, a few bits, repeated start, stop
   localparam int         DIRECTED_COUNT = 22;
   localparam logic [43:0] DIRECTED_LINES =
      44'b1110_1110_0110_1111_0100_1011_1000_0111_0111_0111_1011;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_scl_level = 1'b1;
   logic        req_sda_level = 1'b1;
   logic [7:0]  req_tx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_sda_pull_low;
   logic        rsp_rx_valid;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_tx_pop;
   logic        rsp_addressed;
   logic        rsp_read_transfer;
   logic        rsp_bus_busy;
   logic        rsp_timeout_flag;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_OWN_ADDRESS;
   logic [15:0] csr_wdata = 16'h0000;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;

   // idling knobs, percent per cycle
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;

   // last levels put on the bus and our copy of the registers
   logic        bus_scl = 1'b1;
   logic        bus_sda = 1'b1;
   logic [6:0]  cfg_own = 7'd0;
   logic [15:0] cfg_limit = TIMEOUT_RESET;
   int          hold_max = 3;
   int          items_sent = 0;

   i2c_target_line_sampler_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_scl_level     (req_scl_level),
      .req_sda_level     (req_sda_level),
      .req_tx_byte       (req_tx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sda_pull_low  (rsp_sda_pull_low),
      .rsp_rx_valid      (rsp_rx_valid),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_tx_pop        (rsp_tx_pop),
      .rsp_addressed     (rsp_addressed),
      .rsp_read_transfer (rsp_read_transfer),
      .rsp_bus_busy      (rsp_bus_busy),
      .rsp_timeout_flag  (rsp_timeout_flag),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   i2cts_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_scl_level     (req_scl_level),
      .req_sda_level     (req_sda_level),
      .req_tx_byte       (req_tx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sda_pull_low  (rsp_sda_pull_low),
      .rsp_rx_valid      (rsp_rx_valid),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_tx_pop        (rsp_tx_pop),
      .rsp_addressed     (rsp_addressed),
      .rsp_read_transfer (rsp_read_transfer),
      .rsp_bus_busy      (rsp_bus_busy),
      .rsp_timeout_flag  (rsp_timeout_flag),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver side: random stall, changed only on the falling edge
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** i2c_target_line_sampler_unit: FAILED **");
         $finish;
      end
   end

   // one sample item: optional idle gap, then hold the payload until taken
   // returns on the falling edge after acceptance with valid still high
   task automatic send_sample(input logic scl, input logic sda, input logic [7:0] tx);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_scl_level <= scl;
      req_sda_level <= sda;
      req_tx_byte   <= tx;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic put_line(input logic scl, input logic sda);
      send_sample(scl, sda, 8'($urandom));
      bus_scl = scl;
      bus_sda = sda;
      items_sent++;
   endtask

   task automatic hold_line(input logic scl, input logic sda, input int n);
      repeat (n) put_line(scl, sda);
   endtask

   // hold lengths stay within the timeout limit so a clean transfer never times out
   function automatic int pick_hold();
      return $urandom_range(1, hold_max);
   endfunction

   // one scl clock: fall with sda unchanged, move sda while low, then high
   task automatic clock_bit(input logic b);
      if (bus_scl) put_line(1'b0, bus_sda);
      hold_line(1'b0, b, pick_hold());
      hold_line(1'b1, b, pick_hold());
   endtask

   // start from idle, or repeated start through an extra clock
   task automatic bus_start();
      if (!(bus_scl && bus_sda)) begin
         if (bus_scl) put_line(1'b0, bus_sda);
         hold_line(1'b0, 1'b1, pick_hold());
         hold_line(1'b1, 1'b1, pick_hold());
      end
      put_line(1'b1, 1'b0);
      hold_line(1'b1, 1'b0, pick_hold() - 1);
   endtask

   task automatic bus_stop();
      if (bus_scl) put_line(1'b0, bus_sda);
      hold_line(1'b0, 1'b0, pick_hold());
      hold_line(1'b1, 1'b0, pick_hold());
      put_line(1'b1, 1'b1);
      hold_line(1'b1, 1'b1, $urandom_range(0, 3));
   endtask

   // one transfer: address byte, ack slot, data bytes, then an ending
   task automatic run_transfer();
      logic [6:0] addr;
      logic       rw;
      logic [7:0] addr_byte;
      logic [7:0] data;
      int         nbytes;
      int         ending;
      addr      = ($urandom_range(99) < 75) ? cfg_own : 7'($urandom);
      rw        = 1'($urandom_range(1));
      addr_byte = {addr, rw};
      nbytes    = $urandom_range(0, 4);
      ending    = $urandom_range(99);

      bus_start();
      for (int i = 7; i >= 0; i--) clock_bit(addr_byte[i]);
      // address ack slot, driven by the target; the sampled level is don't-care
      clock_bit(1'($urandom_range(1)));

      if (addr != cfg_own) begin
         // not ours: bus traffic the target must ignore
         repeat (nbytes * 9) clock_bit(1'($urandom_range(1)));
      end else if (!rw) begin
         for (int n = 0; n < nbytes; n++) begin
            data = 8'($urandom);
            for (int i = 7; i >= 0; i--) clock_bit(data[i]);
            clock_bit(1'($urandom_range(1)));
         end
      end else begin
         for (int n = 0; n < nbytes; n++) begin
            repeat (8) clock_bit(1'($urandom_range(1)));
            // master ack: ack all but the last, usually nack the last
            if (n < nbytes - 1) clock_bit(1'b0);
            else clock_bit($urandom_range(99) < 80);
         end
         // sometimes clock on after the nack
         if ($urandom_range(99) < 30) repeat ($urandom_range(1, 4)) clock_bit(1'b1);
      end

      if (ending < 70) begin
         bus_stop();
      end else if (ending < 85 && cfg_limit <= 16'd40) begin
         // abandon the transfer: lines frozen past the timeout limit
         hold_line(bus_scl, bus_sda, int'(cfg_limit) + 2);
      end
      // otherwise the next transfer begins with a repeated start
   endtask

   // short burst of unstructured line samples
   task automatic noise_burst();
      repeat ($urandom_range(5, 15)) put_line(1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending, let every expected response arrive and the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (3) @(negedge clock);
   endtask

   initial begin : stimulus
      int phase_start;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at reset settings, no idling, tx byte at both extremes
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_sample(DIRECTED_LINES[43 - 2 * i], DIRECTED_LINES[42 - 2 * i],
                     i[0] ? 8'hFF : 8'h00);
         bus_scl = DIRECTED_LINES[43 - 2 * i];
         bus_sda = DIRECTED_LINES[42 - 2 * i];
      end

      // random phases, each with its own register settings and idling mix
      for (int p = 0; p < 4; p++) begin
         drain();
         case (p)
            0: begin
               cfg_own   = 7'h00;
               cfg_limit = 16'd1;
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               cfg_own   = 7'h7F;
               cfg_limit = 16'hFFFF;
               gap_pct   = 53;
               stall_pct = 0;
            end
            2: begin
               cfg_own   = 7'($urandom);
               cfg_limit = 16'($urandom_range(2, 12));
               gap_pct   = 0;
               stall_pct = 53;
            end
            default: begin
               cfg_own   = 7'($urandom);
               cfg_limit = 16'($urandom_range(3, 40));
               gap_pct   = 6;
               stall_pct = 6;
            end
         endcase
         write_csr(CSR_OWN_ADDRESS, {9'd0, cfg_own});
         write_csr(CSR_TIMEOUT_LIMIT, cfg_limit);
         hold_max = (cfg_limit < 16'd3) ? int'(cfg_limit) : 3;

         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(99) < 10) noise_burst();
            else run_transfer();
         end
      end

      drain();
      if (error_count == 0) begin
         $display("** i2c_target_line_sampler_unit: PASSED **");
      end else begin
         $display("** i2c_target_line_sampler_unit: FAILED **");
      end
      $finish;
   end

endmodule : tb_i2c_target_line_sampler_unit

`default_nettype wire
